/* rtl/core/i2f_pkg.sv */
`timescale 1ns / 1ps
package i2f_pkg;

	// Target precision codes.
	typedef enum logic {
		PREC_SGL = 1'b0,
		PREC_DBL = 1'b1
	} prec_t;

	localparam logic [63:0] SGL_LIMIT = 64'd16777216;
	localparam logic [63:0] DBL_LIMIT = 64'd9007199254740992;
	localparam int unsigned SGL_BIAS = 127;
	localparam int unsigned DBL_BIAS = 1023;

	// Classified item passed from the front part to the back part.
	typedef struct packed {
		logic        neg;
		logic        dbl;
		logic        zero;
		logic        exact;
		logic [5:0]  lead;
		logic [63:0] mag;
	} cls_t;

	// Input beat payload.
	typedef struct packed {
		logic        operation;
		logic [63:0] value;
	} in_t;

	// Result beat payload.
	typedef struct packed {
		logic [63:0] float_bits;
		logic        exact;
	} res_t;

endpackage

/* rtl/core/i2f_if.sv */
`timescale 1ns / 1ps
interface i2f_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/core/i2f_front.sv */
`timescale 1ns / 1ps
module i2f_front (
	input  logic clk,
	input  logic arst_n,
	i2f_if.sink  in_ch,
	output logic cls_valid,
	input  logic cls_ready,
	output i2f_pkg::cls_t cls
);
	import i2f_pkg::*;

	in_t         item;
	logic [63:0] mag;
	logic [5:0]  lead;
	logic        valid_s1;
	cls_t        cls_s1;

	assign item = in_t'(in_ch.data);

	// Magnitude and leading one position.
	always_comb begin
		mag = item.value[63] ? (64'd0 - item.value) : item.value;
		lead = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (mag[i]) lead = 6'(i);
		end
	end

	assign in_ch.ready = !valid_s1 || cls_ready;

	// Stage register feeding the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			cls_s1.neg <= item.value[63];
			cls_s1.dbl <= item.operation;
			cls_s1.zero <= (mag == 64'd0);
			cls_s1.exact <= (mag <= (prec_t'(item.operation) == PREC_DBL ?
				DBL_LIMIT : SGL_LIMIT));
			cls_s1.lead <= lead;
			cls_s1.mag <= mag;
		end
	end

	assign cls_valid = valid_s1;
	assign cls = cls_s1;
endmodule

/* rtl/core/i2f_queue.sv */
`timescale 1ns / 1ps
module i2f_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  i2f_pkg::cls_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output i2f_pkg::cls_t rd_data
);
	import i2f_pkg::*;

	// Two-entry queue between the front and back parts.
	cls_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       wr_en;
	logic       rd_en;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign wr_en = wr_valid && wr_ready;
	assign rd_en = rd_valid && rd_ready;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wptr_q <= !wptr_q;
			if (rd_en) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(wr_en) - 2'(rd_en);
		end
	end
endmodule

/* rtl/core/i2f_back.sv */
`timescale 1ns / 1ps
module i2f_back (
	input  logic clk,
	input  logic arst_n,
	input  logic cls_valid,
	output logic cls_ready,
	input  i2f_pkg::cls_t cls,
	i2f_if.source out_ch
);
	import i2f_pkg::*;

	logic [63:0] norm;
	logic [52:0] keep;
	logic        lsb;
	logic        guard;
	logic        sticky;
	logic        up;
	logic [53:0] rnd;
	logic [10:0] expo;
	logic [63:0] bits;
	logic        valid_s2;
	res_t        res_s2;

	// Normalize so the leading one sits at bit 63, then round.
	always_comb begin
		norm = cls.mag << (6'd63 - cls.lead);
		bits = 64'd0;
		if (prec_t'(cls.dbl) == PREC_DBL) begin
			keep = norm[63:11];
			lsb = norm[11];
			guard = norm[10];
			sticky = |norm[9:0];
		end else begin
			keep = {29'd0, norm[63:40]};
			lsb = norm[40];
			guard = norm[39];
			sticky = |norm[38:0];
		end
		up = guard && (sticky || lsb);
		rnd = {1'b0, keep} + 54'(up);
		expo = 11'(cls.lead);
		if (prec_t'(cls.dbl) == PREC_DBL) begin
			if (rnd[53]) expo = expo + 11'd1;
			bits = {cls.neg, expo + 11'(DBL_BIAS),
				rnd[53] ? rnd[52:1] : rnd[51:0]};
		end else begin
			if (rnd[24]) expo = expo + 11'd1;
			bits = {32'd0, cls.neg, 8'(expo + 11'(SGL_BIAS)),
				rnd[24] ? rnd[23:1] : rnd[22:0]};
		end
		if (cls.zero) bits = 64'd0;
	end

	// Output register decouples the result consumer.
	assign cls_ready = !valid_s2 || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (cls_ready) begin
			valid_s2 <= cls_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cls_ready && cls_valid) begin
			res_s2.float_bits <= bits;
			res_s2.exact <= cls.exact;
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data = res_s2;
endmodule

/* rtl/core/int64_to_float_converter.sv */
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_ch    in   operation[0], value[63:0]
// out_ch   out  float_bits[63:0], exact
//
// One item per cycle sustained while neither side stalls; an input beat passes
// the front register, the queue and the output register before its result beat.
// The front classifies and finds the leading one; the back shifts and rounds.
// Reset clears all valid state; no clearing pass is needed.
// Either side may stall; the two-entry queue absorbs back stalls.
module int64_to_float_converter (
	input  logic clk,
	input  logic arst_n,
	i2f_if.sink  in_ch,
	i2f_if.source out_ch
);
	import i2f_pkg::*;

	logic cf_valid, cf_ready, qb_valid, qb_ready;
	cls_t cf_data, qb_data;

	i2f_front u_front (.clk, .arst_n, .in_ch, .cls_valid(cf_valid),
		.cls_ready(cf_ready), .cls(cf_data));
	i2f_queue u_queue (.clk, .arst_n, .wr_valid(cf_valid), .wr_ready(cf_ready),
		.wr_data(cf_data), .rd_valid(qb_valid), .rd_ready(qb_ready),
		.rd_data(qb_data));
	i2f_back u_back (.clk, .arst_n, .cls_valid(qb_valid), .cls_ready(qb_ready),
		.cls(qb_data), .out_ch);
endmodule

/* rtl/core/i2f_checker.sv */
`timescale 1ns / 1ps
module i2f_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [64:0] out_data
);
	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	// An exact result whose upper word is zero never has an all-ones single exponent.
	a_upper: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data[0] && out_data[64:33] == 32'd0 |->
		out_data[31:24] != 8'hFF)
		else $error("bad single encoding");
	// A result needs an earlier accepted input beat or an earlier result.
	a_nores: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(in_valid && in_ready) && !$past(out_valid) |-> !out_valid ||
		$past(out_valid, 2) || $past(in_valid && in_ready, 2) ||
		$past(in_valid && in_ready, 3) || $past(out_valid, 3))
		else $error("result without input");
endmodule

bind int64_to_float_converter i2f_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready), .out_valid(out_ch.valid),
	.out_ready(out_ch.ready), .out_data(out_ch.data));

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import i2f_pkg::*;

	localparam int RAND_BEATS = 900;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 10;

	logic clk;
	logic arst_n;
	int cycles = 0;
	int errors = 0;
	int sent = 0;
	int received = 0;
	bit stim_done;
	bit hold_off;

	i2f_if #(.W($bits(in_t))) in_ch ();
	i2f_if #(.W($bits(res_t))) out_ch ();

	int64_to_float_converter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Conversions still owed by the block, oldest first.
	res_t pending_conv[$];

	// Directed stimulus; chk marks rows whose result is typed in.
	typedef struct {
		prec_t       prec;
		logic [63:0] value;
		bit          chk;
		logic [63:0] bits;
		logic        exact;
	} dir_row_t;

	dir_row_t dir_rows[] = '{
		'{PREC_SGL, 64'd0, 1, 64'd0, 1'b1},
		'{PREC_DBL, 64'd0, 1, 64'd0, 1'b1},
		'{PREC_SGL, 64'd1, 1, 64'h3F800000, 1'b1},
		'{PREC_DBL, 64'd1, 1, 64'h3FF0000000000000, 1'b1},
		'{PREC_SGL, -64'sd1, 1, 64'hBF800000, 1'b1},
		'{PREC_DBL, -64'sd1, 1, 64'hBFF0000000000000, 1'b1},
		'{PREC_SGL, 64'h8000000000000000, 1, 64'hDF000000, 1'b0},
		'{PREC_DBL, 64'h8000000000000000, 1, 64'hC3E0000000000000, 1'b0},
		'{PREC_SGL, 64'h7FFFFFFFFFFFFFFF, 1, 64'h5F000000, 1'b0},
		'{PREC_DBL, 64'h7FFFFFFFFFFFFFFF, 1, 64'h43E0000000000000, 1'b0},
		'{PREC_SGL, 64'd16777216, 1, 64'h4B800000, 1'b1},
		'{PREC_SGL, 64'd16777217, 1, 64'h4B800000, 1'b0},
		'{PREC_SGL, -64'sd16777216, 0, 0, 0},
		'{PREC_SGL, -64'sd16777217, 0, 0, 0},
		'{PREC_SGL, 64'd16777219, 0, 0, 0},
		'{PREC_SGL, 64'd33554431, 0, 0, 0},
		'{PREC_DBL, 64'd9007199254740992, 1, 64'h4340000000000000, 1'b1},
		'{PREC_DBL, 64'd9007199254740993, 1, 64'h4340000000000000, 1'b0},
		'{PREC_DBL, -64'sd9007199254740992, 0, 0, 0},
		'{PREC_DBL, -64'sd9007199254740993, 0, 0, 0},
		'{PREC_DBL, 64'd9007199254740995, 0, 0, 0},
		'{PREC_DBL, 64'h003FFFFFFFFFFFFF, 0, 0, 0},
		'{PREC_SGL, 64'h5555555555555555, 0, 0, 0},
		'{PREC_DBL, 64'hAAAAAAAAAAAAAAAA, 0, 0, 0}
	};

	// Round a nonzero magnitude to nearest even and pack it.
	function automatic logic [63:0] pack_float(logic neg, logic [63:0] mag,
			int sig_w, int bias, int sign_at);
		int lead;
		int sh;
		logic [63:0] kept;
		logic [63:0] rem;
		logic [63:0] half;
		logic [63:0] packed_bits;
		lead = 63;
		while (!mag[lead])
			lead--;
		if (lead <= sig_w - 1) begin
			kept = mag << (sig_w - 1 - lead);
		end else begin
			sh = lead - (sig_w - 1);
			rem = mag & ((64'd1 << sh) - 1);
			half = 64'd1 << (sh - 1);
			kept = mag >> sh;
			if (rem > half || (rem == half && kept[0]))
				kept++;
			if ((kept >> sig_w) != 0) begin
				kept = kept >> 1;
				lead++;
			end
		end
		packed_bits = (64'(neg) << sign_at) | (64'(lead + bias) << (sig_w - 1));
		packed_bits |= kept & ((64'd1 << (sig_w - 1)) - 1);
		return packed_bits;
	endfunction

	function automatic res_t convert_int(prec_t prec, logic [63:0] value);
		res_t r;
		logic neg;
		logic [63:0] mag;
		neg = value[63];
		mag = neg ? -value : value;
		if (mag == 0)
			r.float_bits = '0;
		else if (prec == PREC_DBL)
			r.float_bits = pack_float(neg, mag, 53, DBL_BIAS, 63);
		else
			r.float_bits = pack_float(neg, mag, 24, SGL_BIAS, 31) & 64'hFFFFFFFF;
		r.exact = (mag <= ((prec == PREC_DBL) ? DBL_LIMIT : SGL_LIMIT));
		return r;
	endfunction

	// Random value with a random bit length, so that every exponent shows up.
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		int len;
		v = {$urandom, $urandom};
		len = $urandom_range(64, 1);
		if (len < 64)
			v = v & ((64'd1 << len) - 1);
		if ($urandom_range(3, 0) == 0)
			v = -v;
		return v;
	endfunction

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("int64_to_float_converter regression: fail");
			$finish;
		end
	end

	// Offer one beat and hold it until accepted.
	task automatic send_beat(prec_t prec, logic [63:0] value, bit typed,
			res_t typed_res);
		in_t beat;
		beat.operation = prec;
		beat.value = value;
		in_ch.valid <= 1'b1;
		in_ch.data <= beat;
		pending_conv.push_back(typed ? typed_res : convert_int(prec, value));
		do
			@(posedge clk);
		while (!in_ch.ready);
		sent++;
	endtask

	// Random gap with valid low, sent after some beats and bursts.
	task automatic send_gap();
		in_ch.valid <= 1'b0;
		repeat ($urandom_range(4, 1)) @(posedge clk);
	endtask

	// Sender: directed table, then random bursts.
	initial begin
		int burst;
		res_t typed_res;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		stim_done = 0;
		@(posedge arst_n);
		@(posedge clk);
		foreach (dir_rows[i]) begin
			typed_res.float_bits = dir_rows[i].bits;
			typed_res.exact = dir_rows[i].exact;
			send_beat(dir_rows[i].prec, dir_rows[i].value, dir_rows[i].chk, typed_res);
			if ($urandom_range(3, 0) == 0)
				send_gap();
		end
		while (sent < dir_rows.size() + RAND_BEATS) begin
			burst = $urandom_range(40, 1);
			repeat (burst)
				send_beat(prec_t'($urandom_range(1, 0)), rand_value(), 0, '0);
			if ($urandom_range(2, 0) != 0)
				send_gap();
		end
		in_ch.valid <= 1'b0;
		stim_done = 1;
	end

	// Receiver: stall pattern, with one long hold-off early in the random part.
	initial begin
		int phase;
		out_ch.ready = 1'b0;
		hold_off = 0;
		phase = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (sent >= 40 && !hold_off) begin
				hold_off = 1;
				out_ch.ready <= 1'b0;
				repeat (60) @(posedge clk);
			end
			if ((phase / 64) % 3 == 2)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(3, 0) != 0) && (phase % 11 != 5);
		end
	end

	// Result check against the oldest owed conversion.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			received++;
			if (pending_conv.size() == 0) begin
				$error("result beat with nothing expected: %h", got);
				errors++;
			end else begin
				want = pending_conv.pop_front();
				if (got.float_bits !== want.float_bits) begin
					$error("float_bits: expected %h, got %h", want.float_bits,
						got.float_bits);
					errors++;
				end
				if (got.exact !== want.exact) begin
					$error("exact: expected %b, got %b", want.exact, got.exact);
					errors++;
				end
			end
		end
	end

	// End of run.
	initial begin
		wait (stim_done);
		while (pending_conv.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_conv.size() != 0)
			errors++;
		$display("Converted %0d integers (%0d directed) to single and double.",
			sent, dir_rows.size());
		$display("Checked %0d results under random input gaps and output stalls.",
			received);
		if (errors == 0)
			$display("int64_to_float_converter regression: pass");
		else
			$display("int64_to_float_converter regression: fail");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/i2f_pkg.sv
rtl/core/i2f_if.sv
rtl/core/i2f_front.sv
rtl/core/i2f_queue.sv
rtl/core/i2f_back.sv
rtl/core/int64_to_float_converter.sv
rtl/core/i2f_checker.sv
bench/tb_top.sv
